// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/skv_pkg.sv -----
`default_nettype none

package skv_pkg;

    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam int BATCH_W = 4;
    localparam int COL_IN_W = 8;
    localparam int PHYS_W  = 16;
    localparam int QUERY_W = 4;
    localparam int HEAD_W  = 3;
    localparam int SLOT_W  = 6;
    localparam int SEL_W   = 12;

    localparam int CNT_W   = 7;
    localparam int BL_W    = 8;
    localparam int PAGE_W  = 10;
    localparam int HC_W    = 4;
    localparam int QC_W    = 5;

    localparam int SRC_W   = 25;
    localparam int DST_W   = 24;
    localparam int SEQ_W   = 14;
    localparam int SEQ_MAX = 16383;

    localparam int THR_W   = 10;
    localparam int TERM_W  = 14;
    localparam int POS_W   = 22;
    localparam int D1_W    = 10;
    localparam int D2_W    = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRONT_COUNT = 3'd0,
        CFG_NEAR_COUNT  = 3'd1,
        CFG_TOPK_COUNT  = 3'd2,
        CFG_BLOCK_LEN   = 3'd3,
        CFG_PAGE_SIZE   = 3'd4,
        CFG_HEAD_COUNT  = 3'd5,
        CFG_QUERY_COUNT = 3'd6
    } cfg_idx_t;

    typedef enum logic {
        OP_TABLE_WRITE = 1'b0,
        OP_SLOT        = 1'b1
    } op_t;

    typedef struct packed {
        logic                res;
        op_t                 op;
        logic [BATCH_W-1:0]  batch;
        logic [COL_IN_W-1:0] col;
        logic [PHYS_W-1:0]   phys;
        logic                last;
        logic [SEQ_W-1:0]    seq_len;
    } item_t;

endpackage

`default_nettype wire

// ----- rtl/sparse_kv_slot_address_gen.sv -----
// Gather address generator for sparse key/value selection over a paged cache. Each
// s_tdata transaction with tuser 0 writes one page table entry (batch, column ->
// physical page); with tuser 1 it computes one selection slot and, when the slot index
// is below the top-k count, yields one m_tdata transaction holding the physical source
// row, the packed destination row and, on the final slot (tlast), the total selected
// length; tuser on the output flags a position outside the table or a zero page size.
// A new transaction is taken every cycle while the output is not stalled. The row is
// split by page_size in a restoring divider, one quotient bit per stage, followed by
// the synchronous page table read and the page multiply. The page table
// powers up undefined; slots must only read entries already written. Configuration
// writes are accepted every cycle and must only be issued while the block is idle.
`default_nettype none

module sparse_kv_slot_address_gen #(
    parameter int MAX_BATCH    = 16,
    parameter int TABLE_COLS   = 256,
    parameter int PAGE_ID_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // cfg_data: register value, low bits used
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [skv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [skv_pkg::CFG_DATA_W-1:0] cfg_data,
    // s_tdata: batch_idx, table_col, phys_page, query_idx, head_idx, slot_idx,
    //          selected_index, selected_len, zero fill
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [skv_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: op
    input  wire logic                           s_tuser,
    // m_tdata: source_row, dest_row, seq_len, zero fill
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [skv_pkg::M_DATA_W-1:0]        m_tdata,
    // m_tlast: last_slot
    output logic                                m_tlast,
    // m_tuser: out_of_range
    output logic                                m_tuser
);

    import skv_pkg::*;

    localparam int COL_W  = (TABLE_COLS > 1) ? $clog2(TABLE_COLS) : 1;
    localparam int DEPTH  = MAX_BATCH * TABLE_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W  = $clog2(TABLE_COLS + 1) + PAGE_W;
    localparam int CMP_W  = (LIM_W > POS_W) ? LIM_W : POS_W;
    localparam int PROD_W = PAGE_ID_BITS + PAGE_W;

    // configuration registers
    logic [CNT_W-1:0]  front_count_reg;
    logic [CNT_W-1:0]  near_count_reg;
    logic [CNT_W-1:0]  topk_count_reg;
    logic [BL_W-1:0]   block_len_reg;
    logic [PAGE_W-1:0] page_size_reg;
    logic [HC_W-1:0]   head_count_reg;
    logic [QC_W-1:0]   query_count_reg;
    logic [CMP_W-1:0]  lim_reg;

    logic adv;

    // input fields
    logic [BATCH_W-1:0]  in_batch;
    logic [COL_IN_W-1:0] in_col;
    logic [PHYS_W-1:0]   in_phys;
    logic [QUERY_W-1:0]  in_query;
    logic [HEAD_W-1:0]   in_head;
    logic [SLOT_W-1:0]   in_slot;
    logic [SEL_W-1:0]    in_sel_idx;
    logic [SEL_W-1:0]    in_sel_len;

    // stage a
    item_t                    a_it_next, a_it_reg;
    logic                     a_v_reg;
    logic signed [TERM_W-1:0] a_term_next, a_term_reg;
    logic [D1_W-1:0]          a_d1_next, a_d1_reg;
    logic [HEAD_W-1:0]        a_head_reg;
    logic [SLOT_W-1:0]        a_slot_reg;
    logic signed [THR_W-1:0]  thr;
    logic signed [THR_W-1:0]  slot_sx;
    logic [CNT_W-1:0]         slot_inc;
    logic [SEQ_W:0]           seq_prod;

    // stage b
    item_t                    b_it_reg;
    logic                     b_v_reg;
    logic signed [POS_W-1:0]  b_pos_next, b_pos_reg;
    logic signed [POS_W-1:0]  term_x, bl_x;
    logic [D2_W-1:0]          b_d2_next, b_d2_reg;
    logic [SLOT_W-1:0]        b_slot_reg;

    // divider pipe
    logic                     dv_v_reg   [COL_W+1];
    item_t                    dv_it_reg  [COL_W+1];
    logic [CMP_W-1:0]         dv_rem_reg [COL_W+1];
    logic [COL_W-1:0]         dv_quo_reg [COL_W+1];
    logic                     dv_oor_reg [COL_W+1];
    logic [DST_W-1:0]         dv_dst_reg [COL_W+1];
    logic [CMP_W-1:0]         dv_rem_next;
    logic                     dv_oor_next;
    logic [DST_W-1:0]         dv_dst_next;
    logic                     batch_oob;

    // memory stage
    logic [PAGE_ID_BITS-1:0]  page_mem [DEPTH];
    logic [PAGE_ID_BITS-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]        mem_addr;
    logic                     mem_we;
    item_t                    dv_last_it;
    logic                     m_v_reg;
    item_t                    m_it_reg;
    logic                     m_oor_reg;
    logic [PAGE_W-1:0]        m_tail_reg;
    logic [DST_W-1:0]         m_dst_next, m_dst_reg;

    // output register
    logic                     out_valid_reg;
    logic [SRC_W-1:0]         out_src_next, out_src_reg;
    logic [DST_W-1:0]         out_dst_reg;
    logic [SEQ_W-1:0]         out_seq_reg;
    logic                     out_last_reg;
    logic                     out_oor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_count_reg <= CNT_W'(1);
            near_count_reg  <= CNT_W'(2);
            topk_count_reg  <= CNT_W'(16);
            block_len_reg   <= BL_W'(64);
            page_size_reg   <= PAGE_W'(128);
            head_count_reg  <= HC_W'(1);
            query_count_reg <= QC_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FRONT_COUNT: front_count_reg <= cfg_data[CNT_W-1:0];
                CFG_NEAR_COUNT:  near_count_reg  <= cfg_data[CNT_W-1:0];
                CFG_TOPK_COUNT:  topk_count_reg  <= cfg_data[CNT_W-1:0];
                CFG_BLOCK_LEN:   block_len_reg   <= cfg_data[BL_W-1:0];
                CFG_PAGE_SIZE:   page_size_reg   <= cfg_data[PAGE_W-1:0];
                CFG_HEAD_COUNT:  head_count_reg  <= cfg_data[HC_W-1:0];
                CFG_QUERY_COUNT: query_count_reg <= cfg_data[QC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg <= CMP_W'(TABLE_COLS) * CMP_W'(page_size_reg);
    end

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    assign in_batch   = s_tdata[3:0];
    assign in_col     = s_tdata[11:4];
    assign in_phys    = s_tdata[27:12];
    assign in_query   = s_tdata[31:28];
    assign in_head    = s_tdata[34:32];
    assign in_slot    = s_tdata[40:35];
    assign in_sel_idx = s_tdata[52:41];
    assign in_sel_len = s_tdata[64:53];

    // stage a: slot region, signed block term, first packing step
    always_comb
    begin
        thr      = THR_W'(topk_count_reg) - THR_W'(near_count_reg) - THR_W'(front_count_reg);
        slot_sx  = THR_W'(in_slot);
        slot_inc = CNT_W'(in_slot) + CNT_W'(1);
        seq_prod = (SEQ_W+1)'(topk_count_reg) * (SEQ_W+1)'(block_len_reg);

        if (CNT_W'(in_slot) < front_count_reg)
            a_term_next = TERM_W'(in_slot);
        else if (slot_sx > thr)
            a_term_next = TERM_W'(in_sel_len) + TERM_W'(in_slot) - TERM_W'(topk_count_reg)
                        + TERM_W'(front_count_reg) - TERM_W'(1);
        else
            a_term_next = TERM_W'(in_sel_idx);

        a_it_next.op      = op_t'(s_tuser);
        a_it_next.res     = (op_t'(s_tuser) == OP_SLOT) && (CNT_W'(in_slot) < topk_count_reg);
        a_it_next.batch   = in_batch;
        a_it_next.col     = in_col;
        a_it_next.phys    = in_phys;
        a_it_next.last    = (slot_inc == topk_count_reg);
        if (!a_it_next.last)
            a_it_next.seq_len = '0;
        else if (seq_prod > (SEQ_W+1)'(SEQ_MAX))
            a_it_next.seq_len = SEQ_W'(SEQ_MAX);
        else
            a_it_next.seq_len = seq_prod[SEQ_W-1:0];

        a_d1_next = D1_W'(in_batch) * D1_W'(query_count_reg) + D1_W'(in_query);
    end

    // stage b: logical row, second packing step
    always_comb
    begin
        term_x     = POS_W'(a_term_reg);
        bl_x       = POS_W'(block_len_reg);
        b_pos_next = term_x * bl_x;
        b_d2_next  = D2_W'(a_d1_reg) * D2_W'(head_count_reg) + D2_W'(a_head_reg);
    end

    // divider entry: range checks, third packing step
    always_comb
    begin
        batch_oob   = (32'(b_it_reg.batch) >= 32'(MAX_BATCH));
        dv_rem_next = CMP_W'(b_pos_reg[POS_W-2:0]);
        dv_oor_next = b_pos_reg[POS_W-1] || (page_size_reg == '0) || batch_oob
                    || (dv_rem_next >= lim_reg);
        dv_dst_next = DST_W'(b_d2_reg) * DST_W'(topk_count_reg) + DST_W'(b_slot_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg    <= 1'b0;
            b_v_reg    <= 1'b0;
            dv_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg     <= s_tvalid;
            b_v_reg     <= a_v_reg;
            dv_v_reg[0] <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_it_reg   <= a_it_next;
            a_term_reg <= a_term_next;
            a_d1_reg   <= a_d1_next;
            a_head_reg <= in_head;
            a_slot_reg <= in_slot;

            b_it_reg   <= a_it_reg;
            b_pos_reg  <= b_pos_next;
            b_d2_reg   <= b_d2_next;
            b_slot_reg <= a_slot_reg;

            dv_it_reg[0]  <= b_it_reg;
            dv_rem_reg[0] <= dv_rem_next;
            dv_quo_reg[0] <= '0;
            dv_oor_reg[0] <= dv_oor_next;
            dv_dst_reg[0] <= dv_dst_next;
        end
    end

    // restoring division: one quotient bit per stage, most significant first
    for (genvar k = 0; k < COL_W; k++)
    begin : g_div
        localparam int J = COL_W - 1 - k;
        logic [CMP_W-1:0] dsr;
        logic             ge;

        assign dsr = CMP_W'(page_size_reg) << J;
        assign ge  = (dv_rem_reg[k] >= dsr);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[k+1] <= 1'b0;
            else if (adv)
                dv_v_reg[k+1] <= dv_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_it_reg[k+1]  <= dv_it_reg[k];
                dv_oor_reg[k+1] <= dv_oor_reg[k];
                dv_dst_reg[k+1] <= dv_dst_reg[k];
                dv_rem_reg[k+1] <= ge ? (dv_rem_reg[k] - dsr) : dv_rem_reg[k];
                dv_quo_reg[k+1] <= ge ? (dv_quo_reg[k] | (COL_W'(1) << J)) : dv_quo_reg[k];
            end
        end
    end

    // page table access: writes and reads stay in transaction order
    always_comb
    begin
        dv_last_it = dv_it_reg[COL_W];
        mem_we     = dv_v_reg[COL_W] && (dv_last_it.op == OP_TABLE_WRITE)
                  && (32'(dv_last_it.batch) < 32'(MAX_BATCH))
                  && (32'(dv_last_it.col) < 32'(TABLE_COLS));
        if (dv_last_it.op == OP_TABLE_WRITE)
            mem_addr = ADDR_W'(32'(dv_last_it.batch) * 32'(TABLE_COLS) + 32'(dv_last_it.col));
        else
            mem_addr = ADDR_W'(32'(dv_last_it.batch) * 32'(TABLE_COLS)
                     + 32'(dv_quo_reg[COL_W]));
        m_dst_next = DST_W'(dv_dst_reg[COL_W]) * DST_W'(block_len_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (mem_we)
                page_mem[mem_addr] <= PAGE_ID_BITS'(dv_last_it.phys);
            rd_data_reg <= page_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_v_reg       <= dv_v_reg[COL_W];
            out_valid_reg <= m_v_reg && m_it_reg.res;
        end
    end

    always_comb
    begin
        if (m_oor_reg)
            out_src_next = '0;
        else
            out_src_next = SRC_W'(PROD_W'(rd_data_reg) * PROD_W'(page_size_reg)
                         + PROD_W'(m_tail_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_it_reg   <= dv_last_it;
            m_oor_reg  <= dv_oor_reg[COL_W];
            m_tail_reg <= PAGE_W'(dv_rem_reg[COL_W]);
            m_dst_reg  <= m_dst_next;

            out_src_reg  <= out_src_next;
            out_dst_reg  <= m_dst_reg;
            out_seq_reg  <= m_it_reg.seq_len;
            out_last_reg <= m_it_reg.last;
            out_oor_reg  <= m_oor_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_seq_reg, out_dst_reg, out_src_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_oor_reg;

`include "assert_macros.svh"

    `ASSERT_IMPLY(a_oor_src_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata[24:0] == '0)
    `ASSERT_IMPLY(a_seq_only_last, clk, rst_n, m_tvalid && !m_tlast, m_tdata[62:49] == '0)
    `ASSERT_NEXT(a_stall_freezes, clk, rst_n, !adv, $stable({a_v_reg, b_v_reg, m_v_reg}))

endmodule

`default_nettype wire

// ----- test/slot_address_checker.sv -----
`timescale 1ns / 1ps

module slot_address_checker
    import skv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  m_tlast,
    input  logic                  m_tuser,
    output int                    errors,
    output int                    pending
);

    localparam int BATCHES   = 16;
    localparam int PAGE_COLS = 256;

    typedef struct packed {
        logic [SRC_W-1:0] source_row;
        logic [DST_W-1:0] dest_row;
        logic [SEQ_W-1:0] seq_len;
        logic             last_slot;
        logic             out_of_range;
    } slot_addr_t;

    logic [PHYS_W-1:0] page_map [0:BATCHES*PAGE_COLS-1];
    logic [CNT_W-1:0]  front_n;
    logic [CNT_W-1:0]  near_n;
    logic [CNT_W-1:0]  topk_n;
    logic [BL_W-1:0]   blk_len;
    logic [PAGE_W-1:0] page_rows;
    logic [HC_W-1:0]   heads;
    logic [QC_W-1:0]   queries;
    slot_addr_t        due_addrs [$];

    function automatic slot_addr_t predict_slot(
        input logic [BATCH_W-1:0] batch,
        input logic [QUERY_W-1:0] query,
        input logic [HEAD_W-1:0]  head,
        input logic [SLOT_W-1:0]  slot,
        input logic [SEL_W-1:0]   sel_idx,
        input logic [SEL_W-1:0]   sel_len
    );
        slot_addr_t r;
        longint     fc, nc, tk, bl, ps, s, pos, col, tail, src, dst, seq;
        r  = '0;
        fc = longint'(front_n);
        nc = longint'(near_n);
        tk = longint'(topk_n);
        bl = longint'(blk_len);
        ps = longint'(page_rows);
        s  = longint'(slot);
        if (s < fc)
            pos = s * bl;
        else if (s > tk - nc - fc)
            pos = (longint'(sel_len) - nc + (s - (tk - fc - nc)) - 1) * bl;
        else
            pos = longint'(sel_idx) * bl;

        if (pos < 0 || ps == 0)
        begin
            r.out_of_range = 1'b1;
        end
        else
        begin
            col  = pos / ps;
            tail = pos % ps;
            if (col >= PAGE_COLS)
            begin
                r.out_of_range = 1'b1;
            end
            else
            begin
                src = longint'(page_map[int'(batch) * PAGE_COLS + int'(col)]) * ps + tail;
                r.source_row = src[SRC_W-1:0];
            end
        end

        dst = longint'(batch) * longint'(queries) + longint'(query);
        dst = dst * longint'(heads) + longint'(head);
        dst = dst * tk + s;
        dst = dst * bl;
        r.dest_row = dst[DST_W-1:0];

        r.last_slot = (s + 1 == tk);
        if (r.last_slot)
        begin
            seq = tk * bl;
            if (seq > SEQ_MAX)
                seq = SEQ_MAX;
            r.seq_len = seq[SEQ_W-1:0];
        end
        return r;
    endfunction

    task automatic log_fault(input bit had_want, input slot_addr_t want, input slot_addr_t got);
        if (errors < 10)
        begin
            if (!had_want)
                $display("%0t: result with none outstanding: src %0d dst %0d seq %0d last %0b oor %0b",
                         $realtime, got.source_row, got.dest_row, got.seq_len,
                         got.last_slot, got.out_of_range);
            else
                $display("%0t: mismatch: expected src %0d dst %0d seq %0d last %0b oor %0b, got src %0d dst %0d seq %0d last %0b oor %0b",
                         $realtime, want.source_row, want.dest_row, want.seq_len,
                         want.last_slot, want.out_of_range, got.source_row, got.dest_row,
                         got.seq_len, got.last_slot, got.out_of_range);
        end
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slot_addr_t got;
        slot_addr_t want;
        if (!rst_n)
        begin
            front_n   = 7'd1;
            near_n    = 7'd2;
            topk_n    = 7'd16;
            blk_len   = 8'd64;
            page_rows = 10'd128;
            heads     = 4'd1;
            queries   = 5'd1;
            due_addrs.delete();
            errors    = 0;
            pending   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.source_row   = m_tdata[SRC_W-1:0];
                got.dest_row     = m_tdata[SRC_W+DST_W-1:SRC_W];
                got.seq_len      = m_tdata[SRC_W+DST_W+SEQ_W-1:SRC_W+DST_W];
                got.last_slot    = m_tlast;
                got.out_of_range = m_tuser;
                if (due_addrs.size() == 0)
                begin
                    log_fault(1'b0, '0, got);
                end
                else
                begin
                    want = due_addrs.pop_front();
                    if (got.source_row != want.source_row || got.dest_row != want.dest_row ||
                        got.seq_len != want.seq_len || got.last_slot != want.last_slot ||
                        got.out_of_range != want.out_of_range)
                        log_fault(1'b1, want, got);
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FRONT_COUNT: front_n   = cfg_data[CNT_W-1:0];
                    CFG_NEAR_COUNT:  near_n    = cfg_data[CNT_W-1:0];
                    CFG_TOPK_COUNT:  topk_n    = cfg_data[CNT_W-1:0];
                    CFG_BLOCK_LEN:   blk_len   = cfg_data[BL_W-1:0];
                    CFG_PAGE_SIZE:   page_rows = cfg_data[PAGE_W-1:0];
                    CFG_HEAD_COUNT:  heads     = cfg_data[HC_W-1:0];
                    CFG_QUERY_COUNT: queries   = cfg_data[QC_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_TABLE_WRITE)
                    page_map[int'(s_tdata[3:0]) * PAGE_COLS + int'(s_tdata[11:4])] = s_tdata[27:12];
                else if (7'(s_tdata[40:35]) < topk_n)
                    due_addrs.push_back(predict_slot(s_tdata[3:0], s_tdata[31:28],
                                                     s_tdata[34:32], s_tdata[40:35],
                                                     s_tdata[52:41], s_tdata[64:53]));
            end
            pending = due_addrs.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import skv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    int errors;
    int pending;
    int cycle_count = 0;
    int send_idle   = 28;
    int recv_idle   = 54;
    bit hold_req    = 1'b0;
    int fc_set, nc_set, tk_set, bl_set, ps_set;

    sparse_kv_slot_address_gen DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    slot_address_checker addr_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sparse_kv_slot_address_gen test failed");
        $finish;
    end

    // hold off for a long stretch on request, otherwise stall at random
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_item(
        input int b, input int col, input int phys, input int q,
        input int h, input int s, input int idx, input int len
    );
        logic [64:0] f;
        f = {SEL_W'(len), SEL_W'(idx), SLOT_W'(s), HEAD_W'(h), QUERY_W'(q),
             PHYS_W'(phys), COL_IN_W'(col), BATCH_W'(b)};
        return S_DATA_W'(f);
    endfunction

    task automatic push(input op_t op, input logic [S_DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_write(input int b, input int col, input int phys);
        push(OP_TABLE_WRITE, pack_item(b, col, phys, $urandom_range(15), $urandom_range(7),
                                       $urandom_range(63), $urandom_range(4095),
                                       $urandom_range(4095)));
    endtask

    task automatic send_slot(input int b, input int q, input int h, input int s,
                             input int idx, input int len);
        push(OP_SLOT, pack_item(b, $urandom_range(255), $urandom_range(65535), q, h, s, idx, len));
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // drop valid and let the pipeline empty, including items with no result
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (24) @(negedge clk);
    endtask

    task automatic configure(input int fc, input int nc, input int tk, input int bl,
                             input int ps, input int hc, input int qc);
        settle();
        cfg_write(CFG_FRONT_COUNT, fc);
        cfg_write(CFG_NEAR_COUNT, nc);
        cfg_write(CFG_TOPK_COUNT, tk);
        cfg_write(CFG_BLOCK_LEN, bl);
        cfg_write(CFG_PAGE_SIZE, ps);
        cfg_write(CFG_HEAD_COUNT, hc);
        cfg_write(CFG_QUERY_COUNT, qc);
        cfg_valid <= 1'b0;
        fc_set = fc;
        nc_set = nc;
        tk_set = tk;
        bl_set = bl;
        ps_set = ps;
    endtask

    // slots use only the batches whose page table is filled
    function automatic int pick_batch();
        return ($urandom_range(1) == 0) ? 0 : 15;
    endfunction

    // keep most block indexes inside the table so translation is exercised
    function automatic int pick_index();
        int lim;
        if (ps_set == 0 || $urandom_range(3) == 0)
            return $urandom_range(4095);
        lim = 256 * ps_set / bl_set - 1;
        if (lim > 4095)
            lim = 4095;
        return $urandom_range(lim);
    endfunction

    function automatic int pick_length();
        int lim;
        if (ps_set == 0 || $urandom_range(3) == 0)
            return $urandom_range(4095);
        lim = 256 * ps_set / bl_set + nc_set + 1;
        if (lim > 4095)
            lim = 4095;
        return $urandom_range(lim);
    endfunction

    task automatic random_traffic(input int budget);
        int sent;
        int pick;
        int b, q, h, len, stop;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                send_write($urandom_range(15), $urandom_range(255), $urandom_range(65535));
                sent++;
            end
            else if (pick < 20)
            begin
                send_slot(pick_batch(), $urandom_range(15), $urandom_range(7),
                          $urandom_range(63), $urandom_range(4095), $urandom_range(4095));
                sent++;
            end
            else
            begin
                b    = pick_batch();
                q    = $urandom_range(15);
                h    = $urandom_range(7);
                len  = pick_length();
                stop = ($urandom_range(6) == 0) ? $urandom_range(tk_set - 1) : tk_set - 1;
                for (int s = 0; s <= stop; s++)
                begin
                    send_slot(b, q, h, s, pick_index(), len);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_TABLE_WRITE;
        fc_set    = 1;
        nc_set    = 2;
        tk_set    = 16;
        bl_set    = 64;
        ps_set    = 128;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fill batches 0 and 15 so no slot ever reads an unwritten entry
        for (int b = 0; b < 16; b += 15)
            for (int c = 0; c < 256; c++)
                send_write(b, c, $urandom_range(65535));

        send_write(0, 0, 16'h0000);
        send_write(15, 255, 16'hFFFF);
        send_write(3, 7, 1234);
        send_slot(3, 1, 2, 5, 14, 0);
        send_slot(0, 0, 0, 0, 0, 0);
        send_slot(15, 15, 7, 0, 4095, 4095);
        send_slot(15, 2, 3, 7, 511, 0);
        send_slot(15, 2, 3, 8, 510, 0);
        send_slot(4, 0, 0, 9, 512, 0);
        send_slot(4, 0, 0, 13, 4095, 0);
        send_slot(5, 0, 0, 14, 0, 0);
        send_slot(0, 0, 0, 15, 0, 3);
        send_slot(15, 15, 7, 15, 0, 512);
        send_slot(6, 0, 0, 15, 0, 4095);
        send_slot(7, 0, 0, 16, 0, 0);
        send_slot(7, 0, 0, 63, 4095, 4095);

        configure(0, 0, 1, 1, 1, 1, 1);
        random_traffic(120);
        configure(64, 64, 64, 128, 512, 8, 16);
        hold_req = 1'b1;
        random_traffic(130);

        send_idle = 54;
        recv_idle = 28;
        configure(3, 4, 20, 16, 64, 4, 8);
        random_traffic(120);
        configure(2, 3, 8, 7, 0, 2, 3);
        random_traffic(90);
        configure(40, 10, 48, 100, 300, 15, 31);
        random_traffic(110);

        send_idle = 0;
        recv_idle = 0;
        configure(6, 5, 9, 33, 37, 3, 5);
        hold_req = 1'b1;
        random_traffic(110);
        configure(1, 2, 16, 64, 128, 1, 1);
        random_traffic(40);

        settle();
        if (errors == 0 && pending == 0)
            $display("sparse_kv_slot_address_gen test passed");
        else
            $display("sparse_kv_slot_address_gen test failed");
        $finish;
    end

endmodule
